// ----- hdl/es2c_pkg.sv -----
package es2c_pkg;

  // Field widths
  localparam int unsigned EpochWidth  = 32;
  localparam int unsigned YearWidth   = 12;
  localparam int unsigned MonthWidth  = 4;
  localparam int unsigned DayWidth    = 5;
  localparam int unsigned HourWidth   = 5;
  localparam int unsigned MinuteWidth = 6;
  localparam int unsigned SecondWidth = 6;

  // Whole days since the epoch: 2^32 / 86400 < 2^16
  localparam int unsigned DayQuotBits = 16;

  localparam logic [EpochWidth-1:0] SecsPerDay  = 32'd86400;
  localparam logic [EpochWidth-1:0] SecsPerHour = 32'd3600;
  localparam logic [EpochWidth-1:0] SecsPerMin  = 32'd60;

  // Reciprocals for exact division by multiply and shift
  // days   = ((secs >> 7) * DayRecip)  >> 35, 86400 = 2^7 * 675, secs >> 7 below 2^25
  // hour   = ((sod  >> 4) * HourRecip) >> 21, 3600  = 2^4 * 225, sod >> 4 below 2^13
  // minute = ((soh  >> 2) * MinRecip)  >> 14, 60    = 2^2 * 15,  soh >> 2 below 2^10
  localparam logic [25:0] DayRecip  = 26'd50903317;  // ceil(2^35 / 675)
  localparam logic [13:0] HourRecip = 14'd9321;      // ceil(2^21 / 225)
  localparam logic [10:0] MinRecip  = 11'd1093;      // ceil(2^14 / 15)

  localparam logic [YearWidth-1:0] EpochYear = 12'd1970;
  localparam logic [6:0]           EpochMod100 = 7'd70;
  localparam logic [8:0]           EpochMod400 = 9'd370;
  localparam logic [6:0]           LastMod100  = 7'd99;
  localparam logic [8:0]           LastMod400  = 9'd399;
  localparam logic [MonthWidth-1:0] LastMonth  = 4'd11;

  localparam logic [8:0] DaysPerYear     = 9'd365;
  localparam logic [8:0] DaysPerLeapYear = 9'd366;

  // Datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DAY_DIV,
    CMD_DAY_REM,
    CMD_HOUR_DIV,
    CMD_HOUR_REM,
    CMD_MIN_DIV,
    CMD_MIN_REM,
    CMD_SETUP_YEAR,
    CMD_YEAR_STEP,
    CMD_MONTH_STEP,
    CMD_PUBLISH
  } cmd_e;

  // Datapath status
  typedef struct packed {
    logic year_done;
    logic month_done;
  } status_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY_DIV,
    ST_DAY_REM,
    ST_HOUR_DIV,
    ST_HOUR_REM,
    ST_MIN_DIV,
    ST_MIN_REM,
    ST_YEAR_SET,
    ST_YEAR,
    ST_MONTH,
    ST_PUBLISH
  } state_e;

  // Days in a month, month counted from 0
  function automatic logic [DayWidth-1:0] month_len(input logic leap,
                                                    input logic [MonthWidth-1:0] mon);
    logic [DayWidth-1:0] len;
    case (mon)
      4'd1: begin
        len = leap ? 5'd29 : 5'd28;
      end
      4'd3, 4'd5, 4'd8, 4'd10: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

endpackage

// ----- hdl/es2c_datapath.sv -----
module es2c_datapath (
  input  logic                                clk_i,
  input  es2c_pkg::cmd_e                      cmd_i,
  output es2c_pkg::status_t                   status_o,
  input  logic [es2c_pkg::EpochWidth-1:0]     epoch_seconds_i,
  output logic [es2c_pkg::YearWidth-1:0]      year_o,
  output logic [es2c_pkg::MonthWidth-1:0]     month_o,
  output logic [es2c_pkg::DayWidth-1:0]       day_of_month_o,
  output logic [es2c_pkg::HourWidth-1:0]      hour_o,
  output logic [es2c_pkg::MinuteWidth-1:0]    minute_o,
  output logic [es2c_pkg::SecondWidth-1:0]    second_o
);

  logic [es2c_pkg::EpochWidth-1:0]   rem_q;
  logic [es2c_pkg::DayQuotBits-1:0]  days_q;
  logic [es2c_pkg::HourWidth-1:0]    hour_q;
  logic [es2c_pkg::MinuteWidth-1:0]  minute_q;
  logic [es2c_pkg::YearWidth-1:0]    year_q;
  logic [6:0]                        mod100_q;
  logic [8:0]                        mod400_q;
  logic [es2c_pkg::MonthWidth-1:0]   mon_q;

  logic [50:0]                       day_prod;
  logic [25:0]                       hour_prod;
  logic [19:0]                       min_prod;
  logic [es2c_pkg::EpochWidth-1:0]   day_base;
  logic [es2c_pkg::EpochWidth-1:0]   hour_base;
  logic [es2c_pkg::EpochWidth-1:0]   min_base;
  logic                              leap;
  logic [8:0]                        year_len;
  logic [es2c_pkg::DayWidth-1:0]     mon_len;

  // Reciprocal products for the day, hour and minute quotients
  assign day_prod  = {26'd0, rem_q[31:7]} * {25'd0, es2c_pkg::DayRecip};
  assign hour_prod = {13'd0, rem_q[16:4]} * {12'd0, es2c_pkg::HourRecip};
  assign min_prod  = {10'd0, rem_q[11:2]} * {9'd0, es2c_pkg::MinRecip};

  // Seconds covered by each quotient, taken off the remainder
  assign day_base  = {16'd0, days_q} * es2c_pkg::SecsPerDay;
  assign hour_base = {27'd0, hour_q} * es2c_pkg::SecsPerHour;
  assign min_base  = {26'd0, minute_q} * es2c_pkg::SecsPerMin;

  // Leap rule from running year residues
  assign leap     = (mod400_q == '0) || ((mod100_q != '0) && (year_q[1:0] == 2'b00));
  assign year_len = leap ? es2c_pkg::DaysPerLeapYear : es2c_pkg::DaysPerYear;
  assign mon_len  = es2c_pkg::month_len(leap, mon_q);

  assign status_o.year_done  = (days_q < 16'(year_len));
  assign status_o.month_done = (mon_q == es2c_pkg::LastMonth) || (days_q < 16'(mon_len));

  // Working registers, advanced by the controller's command
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      es2c_pkg::CMD_LOAD: begin
        rem_q <= epoch_seconds_i;
      end
      es2c_pkg::CMD_DAY_DIV: begin
        days_q <= day_prod[50:35];
      end
      es2c_pkg::CMD_DAY_REM: begin
        rem_q <= rem_q - day_base;
      end
      es2c_pkg::CMD_HOUR_DIV: begin
        hour_q <= hour_prod[25:21];
      end
      es2c_pkg::CMD_HOUR_REM: begin
        rem_q <= rem_q - hour_base;
      end
      es2c_pkg::CMD_MIN_DIV: begin
        minute_q <= min_prod[19:14];
      end
      es2c_pkg::CMD_MIN_REM: begin
        rem_q <= rem_q - min_base;
      end
      es2c_pkg::CMD_SETUP_YEAR: begin
        year_q   <= es2c_pkg::EpochYear;
        mod100_q <= es2c_pkg::EpochMod100;
        mod400_q <= es2c_pkg::EpochMod400;
        mon_q    <= '0;
      end
      es2c_pkg::CMD_YEAR_STEP: begin
        if (!status_o.year_done) begin
          days_q   <= days_q - 16'(year_len);
          year_q   <= year_q + 12'd1;
          mod100_q <= (mod100_q == es2c_pkg::LastMod100) ? '0 : mod100_q + 7'd1;
          mod400_q <= (mod400_q == es2c_pkg::LastMod400) ? '0 : mod400_q + 9'd1;
        end
      end
      es2c_pkg::CMD_MONTH_STEP: begin
        if (!status_o.month_done) begin
          days_q <= days_q - 16'(mon_len);
          mon_q  <= mon_q + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register, loaded when the result is published
  always_ff @(posedge clk_i) begin
    if (cmd_i == es2c_pkg::CMD_PUBLISH) begin
      year_o         <= year_q;
      month_o        <= mon_q + 4'd1;
      day_of_month_o <= days_q[es2c_pkg::DayWidth-1:0] + 5'd1;
      hour_o         <= hour_q;
      minute_o       <= minute_q;
      second_o       <= rem_q[es2c_pkg::SecondWidth-1:0];
    end
  end

endmodule

// ----- hdl/es2c_ctrl.sv -----
module es2c_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  es2c_pkg::status_t status_i,
  output es2c_pkg::cmd_e    cmd_o
);

  es2c_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= es2c_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == es2c_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequence the conversion phases
  always_comb begin
    state_d     = state_q;
    cmd_o       = es2c_pkg::CMD_NONE;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      es2c_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = es2c_pkg::CMD_LOAD;
          state_d = es2c_pkg::ST_DAY_DIV;
        end
      end
      es2c_pkg::ST_DAY_DIV: begin
        cmd_o   = es2c_pkg::CMD_DAY_DIV;
        state_d = es2c_pkg::ST_DAY_REM;
      end
      es2c_pkg::ST_DAY_REM: begin
        cmd_o   = es2c_pkg::CMD_DAY_REM;
        state_d = es2c_pkg::ST_HOUR_DIV;
      end
      es2c_pkg::ST_HOUR_DIV: begin
        cmd_o   = es2c_pkg::CMD_HOUR_DIV;
        state_d = es2c_pkg::ST_HOUR_REM;
      end
      es2c_pkg::ST_HOUR_REM: begin
        cmd_o   = es2c_pkg::CMD_HOUR_REM;
        state_d = es2c_pkg::ST_MIN_DIV;
      end
      es2c_pkg::ST_MIN_DIV: begin
        cmd_o   = es2c_pkg::CMD_MIN_DIV;
        state_d = es2c_pkg::ST_MIN_REM;
      end
      es2c_pkg::ST_MIN_REM: begin
        cmd_o   = es2c_pkg::CMD_MIN_REM;
        state_d = es2c_pkg::ST_YEAR_SET;
      end
      es2c_pkg::ST_YEAR_SET: begin
        cmd_o   = es2c_pkg::CMD_SETUP_YEAR;
        state_d = es2c_pkg::ST_YEAR;
      end
      es2c_pkg::ST_YEAR: begin
        cmd_o = es2c_pkg::CMD_YEAR_STEP;
        if (status_i.year_done) begin
          state_d = es2c_pkg::ST_MONTH;
        end
      end
      es2c_pkg::ST_MONTH: begin
        cmd_o = es2c_pkg::CMD_MONTH_STEP;
        if (status_i.month_done) begin
          state_d = es2c_pkg::ST_PUBLISH;
        end
      end
      es2c_pkg::ST_PUBLISH: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = es2c_pkg::CMD_PUBLISH;
          out_valid_d = 1'b1;
          state_d     = es2c_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = es2c_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/epoch_seconds_to_calendar_unit.sv -----
// Sequence: after the input transfer, divide and remainder steps for day, hour and
// minute, then the one-year-per-cycle year loop, the month loop and publishing.
// Throughput: one item at a time; the next input is taken once the result sits in the
// output register, which holds it until its transfer.
// Reset: rst_ni is asynchronous, active low; it clears the controller state and output
// valid. Payload registers are not reset.
module epoch_seconds_to_calendar_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [es2c_pkg::EpochWidth-1:0]     epoch_seconds_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [es2c_pkg::YearWidth-1:0]      year_o,
  output logic [es2c_pkg::MonthWidth-1:0]     month_o,
  output logic [es2c_pkg::DayWidth-1:0]       day_of_month_o,
  output logic [es2c_pkg::HourWidth-1:0]      hour_o,
  output logic [es2c_pkg::MinuteWidth-1:0]    minute_o,
  output logic [es2c_pkg::SecondWidth-1:0]    second_o
);

  es2c_pkg::cmd_e    cmd;
  es2c_pkg::status_t status;

  es2c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  es2c_datapath u_datapath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .epoch_seconds_i (epoch_seconds_i),
    .year_o          (year_o),
    .month_o         (month_o),
    .day_of_month_o  (day_of_month_o),
    .hour_o          (hour_o),
    .minute_o        (minute_o),
    .second_o        (second_o)
  );

  // One item in flight: no new transfer right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a conversion is in progress");

  // Published date fields stay in calendar range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_o >= 4'd1) && (month_o <= 4'd12) && (day_of_month_o != 5'd0))
    else $error("month or day out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (year_o >= 12'd1970) && (year_o <= 12'd2106) &&
                    (hour_o <= 5'd23) && (minute_o <= 6'd59) && (second_o <= 6'd59))
    else $error("year or time of day out of range");

endmodule
